/* rtl/core/assert_macros.svh */
// Assertion macros shared by the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Property that must hold at every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`endif

/* rtl/core/ffba_pkg.sv */
// Package with types and constants for the first-fit block allocator.
package ffba_pkg;
    localparam int TableEntriesDef = 256;
    localparam int AddrBitsDef     = 32;

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_ADD   = 2'd2,
        OP_NONE  = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_FIT    = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        E_UNUSED = 2'd0,
        E_FREE   = 2'd1,
        E_USED   = 2'd2
    } estat_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN1,
        S_WAIT1,
        S_DECIDE1,
        S_SCAN2,
        S_WAIT2,
        S_COMMIT,
        S_WR2,
        S_WR3,
        S_OUT
    } state_t;

    // Controller to datapath.
    typedef struct packed {
        logic clear_step; // clear one status entry after reset
        logic load;       // capture the new item
        logic scan_start; // reset index and read-valid flag
        logic scan_step;  // advance index, issue a read
        logic scan_pass2; // second pass of free (neighbour search)
        logic decide;     // evaluate first-pass results
        logic wr_a;       // perform first table write
        logic wr_b;       // second write
        logic wr_c;       // third write
        logic out_load;   // capture the result
    } ffba_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic scan_last;  // issued read is the last entry
        logic done_early; // search satisfied, scan can stop
        logic fail;       // operation ends with an error
        logic need_pass2; // free needs neighbour pass
        logic nwrites_b;  // a second write is needed
        logic nwrites_c;  // a third write is needed
    } ffba_sts_t;
endpackage

/* rtl/core/ffba_ctrl.sv */
// Controller state machine of the first-fit block allocator.
module ffba_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_fire,
    input  logic                 out_busy,
    input  logic                 out_fire,
    input  ffba_pkg::ffba_sts_t  sts,
    output ffba_pkg::ffba_cmd_t  cmd,
    output logic                 in_ready
);
    import ffba_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:   if (sts.scan_last) state_next = S_IDLE;
            S_IDLE:    if (in_fire) state_next = S_SCAN1;
            S_SCAN1:   if (sts.scan_last || sts.done_early) state_next = S_WAIT1;
            S_WAIT1:   state_next = S_DECIDE1;
            S_DECIDE1: begin
                if (sts.fail) state_next = S_OUT;
                else if (sts.need_pass2) state_next = S_SCAN2;
                else state_next = S_COMMIT;
            end
            S_SCAN2:   if (sts.scan_last || sts.done_early) state_next = S_WAIT2;
            S_WAIT2:   state_next = S_COMMIT;
            S_COMMIT:  state_next = sts.nwrites_b ? S_WR2 : S_OUT;
            S_WR2:     state_next = sts.nwrites_c ? S_WR3 : S_OUT;
            S_WR3:     state_next = S_OUT;
            S_OUT:     if (!out_busy || out_fire) state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        in_ready = 1'b0;
        case (state_reg)
            S_CLEAR:   cmd.clear_step = 1'b1;
            S_IDLE: begin
                in_ready = 1'b1;
                cmd.load = in_fire;
                cmd.scan_start = in_fire;
            end
            S_SCAN1:   cmd.scan_step = 1'b1;
            S_DECIDE1: begin
                cmd.decide = 1'b1;
                cmd.scan_start = 1'b1;
            end
            S_SCAN2: begin
                cmd.scan_step = 1'b1;
                cmd.scan_pass2 = 1'b1;
            end
            S_WAIT2:   cmd.scan_pass2 = 1'b1;
            S_COMMIT:  cmd.wr_a = 1'b1;
            S_WR2:     cmd.wr_b = 1'b1;
            S_WR3:     cmd.wr_c = 1'b1;
            S_OUT:     cmd.out_load = !out_busy || out_fire;
            default:   ;
        endcase
    end
endmodule

/* rtl/core/ffba_dpath.sv */
// Datapath of the first-fit block allocator: descriptor table and search logic.
module ffba_dpath #(
    parameter int TABLE_ENTRIES = ffba_pkg::TableEntriesDef,
    parameter int ADDR_BITS     = ffba_pkg::AddrBitsDef
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  ffba_pkg::ffba_cmd_t  cmd,
    input  logic [1:0]           in_opcode,
    input  logic [31:0]          in_size,
    input  logic [31:0]          in_addr,
    output ffba_pkg::ffba_sts_t  sts,
    output logic [31:0]          res_addr,
    output logic [1:0]           res_status
);
    import ffba_pkg::*;

    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam int AW = ADDR_BITS;

    logic [AW-1:0] base_mem [TABLE_ENTRIES];
    logic [AW-1:0] len_mem  [TABLE_ENTRIES];
    // Status entries are cleared one per cycle by the pass after reset.
    logic [1:0]    stat_mem [TABLE_ENTRIES];

    logic [1:0]    op_reg;
    logic [AW-1:0] size_reg, addr_reg;
    logic [IW:0]   idx_reg;            // next entry to read
    logic          rv_reg;             // read data valid
    logic [IW-1:0] ridx_reg;
    logic [AW-1:0] rbase_reg, rlen_reg;
    logic [1:0]    rstat_reg;

    logic          fit_v_reg, spare_v_reg, cur_v_reg, lo_v_reg, hi_v_reg, add_v_reg;
    logic [IW-1:0] fit_i_reg, spare_i_reg, cur_i_reg, lo_i_reg, hi_i_reg, add_i_reg;
    logic [AW-1:0] fit_b_reg, fit_l_reg, cur_b_reg, cur_l_reg, lo_l_reg, hi_l_reg;
    logic [AW-1:0] add_l_reg;
    logic [1:0]    st_reg;
    logic [31:0]   ra_reg;

    // Write port.
    logic          we;
    logic [IW-1:0] wi;
    logic [AW-1:0] wbase, wlen;
    logic          wbase_en, wlen_en, wstat_en;
    logic [1:0]    wstat;

    logic [AW-1:0] rend;
    logic [AW-1:0] cur_end;
    logic [AW-1:0] newlen;
    logic          stop_next;

    assign rend = rbase_reg + rlen_reg;
    assign cur_end = cur_b_reg + cur_l_reg;

    always_ff @(posedge aclk) begin
        if (cmd.scan_step) begin
            rbase_reg <= base_mem[idx_reg[IW-1:0]];
            rlen_reg  <= len_mem[idx_reg[IW-1:0]];
            ridx_reg  <= idx_reg[IW-1:0];
            rstat_reg <= stat_mem[idx_reg[IW-1:0]];
        end
        if (we && wbase_en) base_mem[wi] <= wbase;
        if (we && wlen_en)  len_mem[wi]  <= wlen;
        if (we && wstat_en) stat_mem[wi] <= wstat;
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg   <= in_opcode;
            size_reg <= AW'(in_size);
            addr_reg <= AW'(in_addr);
        end
    end

    // Early stop decision from the entry being examined.
    always_comb begin
        stop_next = 1'b0;
        if (rv_reg) begin
            case (op_reg)
                OP_ALLOC: stop_next = (fit_v_reg || (rstat_reg == E_FREE &&
                                        rlen_reg >= size_reg)) &&
                                      (spare_v_reg || (rstat_reg == E_UNUSED &&
                                        !(rstat_reg == E_FREE)));
                OP_FREE:  stop_next = !cmd.scan_pass2 && rstat_reg == E_USED &&
                                      rbase_reg == addr_reg;
                OP_ADD:   stop_next = rstat_reg == E_FREE && rend == addr_reg;
                default:  stop_next = 1'b0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rv_reg  <= 1'b0;
            idx_reg <= '0;
        end else if (cmd.scan_start) begin
            rv_reg  <= 1'b0;
            idx_reg <= '0;
        end else if (cmd.scan_step || cmd.clear_step) begin
            rv_reg  <= cmd.scan_step;
            idx_reg <= idx_reg + 1'b1;
        end else begin
            rv_reg  <= 1'b0;
        end
    end

    assign sts.scan_last  = idx_reg == (IW+1)'(TABLE_ENTRIES - 1);
    assign sts.done_early = stop_next ||
                            (op_reg == OP_FREE && cmd.scan_pass2 && lo_v_reg && hi_v_reg);
    assign sts.fail = (op_reg == OP_ALLOC && (!fit_v_reg || !spare_v_reg)) ||
                      (op_reg == OP_FREE && !cur_v_reg) ||
                      (op_reg == OP_ADD && !add_v_reg && !spare_v_reg);
    assign sts.need_pass2 = op_reg == OP_FREE;
    assign sts.nwrites_b  = op_reg == OP_ALLOC || op_reg == OP_FREE;
    assign sts.nwrites_c  = op_reg == OP_FREE && lo_v_reg && hi_v_reg;

    // Search flags, updated as each entry's read data arrives.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            fit_v_reg <= 1'b0; spare_v_reg <= 1'b0; cur_v_reg <= 1'b0; add_v_reg <= 1'b0;
        end
        if (cmd.decide) begin
            lo_v_reg <= 1'b0; hi_v_reg <= 1'b0;
        end
        if (rv_reg) begin
            case (op_reg)
                OP_ALLOC: begin
                    if (rstat_reg == E_FREE && !fit_v_reg && rlen_reg >= size_reg) begin
                        fit_v_reg <= 1'b1; fit_i_reg <= ridx_reg;
                        fit_b_reg <= rbase_reg; fit_l_reg <= rlen_reg;
                    end else if (rstat_reg == E_UNUSED && !spare_v_reg) begin
                        spare_v_reg <= 1'b1; spare_i_reg <= ridx_reg;
                    end
                end
                OP_FREE: begin
                    if (!cmd.scan_pass2) begin
                        if (rstat_reg == E_USED && rbase_reg == addr_reg && !cur_v_reg) begin
                            cur_v_reg <= 1'b1; cur_i_reg <= ridx_reg;
                            cur_b_reg <= rbase_reg; cur_l_reg <= rlen_reg;
                        end
                    end else if (ridx_reg != cur_i_reg && rstat_reg == E_FREE) begin
                        if (!lo_v_reg && rend == cur_b_reg) begin
                            lo_v_reg <= 1'b1; lo_i_reg <= ridx_reg; lo_l_reg <= rlen_reg;
                        end else if (!hi_v_reg && rbase_reg == cur_end) begin
                            hi_v_reg <= 1'b1; hi_i_reg <= ridx_reg; hi_l_reg <= rlen_reg;
                        end
                    end
                end
                OP_ADD: begin
                    if (!add_v_reg) begin
                        if (rstat_reg == E_FREE && rend == addr_reg) begin
                            add_v_reg <= 1'b1; add_i_reg <= ridx_reg; add_l_reg <= rlen_reg;
                        end else if (rstat_reg == E_UNUSED) begin
                            spare_v_reg <= 1'b1; spare_i_reg <= ridx_reg;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Write sequencing.
    assign newlen = fit_l_reg - size_reg;
    always_comb begin
        we = 1'b0; wi = '0; wbase = '0; wlen = '0; wstat = E_UNUSED;
        wbase_en = 1'b0; wlen_en = 1'b0; wstat_en = 1'b0;
        if (cmd.clear_step) begin
            we = 1'b1; wi = idx_reg[IW-1:0]; wstat = E_UNUSED; wstat_en = 1'b1;
        end else begin
            case (op_reg)
                OP_ALLOC: begin
                    if (cmd.wr_a) begin
                        we = 1'b1; wi = spare_i_reg; wbase = fit_b_reg; wlen = size_reg;
                        wstat = E_USED; wbase_en = 1'b1; wlen_en = 1'b1; wstat_en = 1'b1;
                    end else if (cmd.wr_b) begin
                        we = 1'b1; wi = fit_i_reg; wbase = fit_b_reg + size_reg;
                        wlen = newlen;
                        wstat = (newlen == '0) ? E_UNUSED : E_FREE;
                        wbase_en = 1'b1; wlen_en = 1'b1; wstat_en = 1'b1;
                    end
                end
                OP_FREE: begin
                    if (cmd.wr_a) begin
                        we = 1'b1; wi = cur_i_reg; wstat_en = 1'b1;
                        wstat = lo_v_reg ? E_UNUSED : E_FREE;
                        if (!lo_v_reg && hi_v_reg) begin
                            wlen_en = 1'b1; wlen = cur_l_reg + hi_l_reg;
                        end
                    end else if (cmd.wr_b) begin
                        if (lo_v_reg) begin
                            we = 1'b1; wi = lo_i_reg; wlen_en = 1'b1;
                            wlen = lo_l_reg + cur_l_reg + (hi_v_reg ? hi_l_reg : '0);
                        end else if (hi_v_reg) begin
                            we = 1'b1; wi = hi_i_reg; wstat_en = 1'b1; wstat = E_UNUSED;
                        end
                    end else if (cmd.wr_c) begin
                        we = 1'b1; wi = hi_i_reg; wstat_en = 1'b1; wstat = E_UNUSED;
                    end
                end
                OP_ADD: begin
                    if (cmd.wr_a) begin
                        we = 1'b1;
                        if (add_v_reg) begin
                            wi = add_i_reg; wlen = add_l_reg + size_reg; wlen_en = 1'b1;
                        end else begin
                            wi = spare_i_reg; wbase = addr_reg; wlen = size_reg;
                            wstat = E_FREE; wbase_en = 1'b1; wlen_en = 1'b1;
                            wstat_en = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Result is latched at decide, for errors and success alike; cleared at load.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            st_reg <= ST_OK;
            ra_reg <= '0;
        end else if (cmd.decide) begin
            case (op_reg)
                OP_ALLOC: begin
                    if (!fit_v_reg) st_reg <= ST_NO_FIT;
                    else if (!spare_v_reg) st_reg <= ST_FULL;
                    else ra_reg <= 32'(fit_b_reg);
                end
                OP_FREE: if (!cur_v_reg) st_reg <= ST_NOT_FOUND;
                OP_ADD: begin
                    if (!add_v_reg && !spare_v_reg) st_reg <= ST_FULL;
                    else ra_reg <= 32'(addr_reg);
                end
                default: ;
            endcase
        end
    end

    assign res_addr   = ra_reg;
    assign res_status = st_reg;
endmodule

/* rtl/core/first_fit_block_allocator_top.sv */
// Top level of the first-fit block allocator.
// The allocator keeps a table of block descriptors (base, length, status).
// One input transfer on the s_ channel carries an operation: allocate,
// free block, or add free region (opcode in tuser). Every operation gives
// exactly one result transfer on the m_ channel with the address and a
// status code (tuser).
// Each operation walks the table through one read port, one entry per
// cycle, stopping early once its search is satisfied. Free alone makes
// a second pass, for neighbours. The next input transfer is taken in
// the cycle after the result register loads; one operation is in flight
// at a time.
// After reset a clearing pass marks every entry unused; s_tready stays
// low until it ends.
// The result is held in an output register; while the receiver stalls the
// next operation may still be taken and worked, and it waits to deliver
// until the held result has gone.
`include "assert_macros.svh"
module first_fit_block_allocator_top #(
    parameter int TABLE_ENTRIES = ffba_pkg::TableEntriesDef,
    parameter int ADDR_BITS     = ffba_pkg::AddrBitsDef
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,  // request_size [31:0], block_address [63:32]
    input  logic [1:0]  s_tuser,  // opcode [1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,  // result_address [31:0]
    output logic [1:0]  m_tuser   // status_code [1:0]
);
    import ffba_pkg::*;

    ffba_cmd_t cmd;
    ffba_sts_t sts;
    logic in_fire, out_fire;
    logic [31:0] res_addr;
    logic [1:0]  res_status;
    logic        mv_reg;
    logic [31:0] md_reg;
    logic [1:0]  mu_reg;

    assign in_fire  = s_tvalid && s_tready;
    assign out_fire = m_tvalid && m_tready;

    ffba_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .in_fire(in_fire), .out_busy(mv_reg),
        .out_fire(out_fire), .sts(sts), .cmd(cmd), .in_ready(s_tready)
    );

    ffba_dpath #(.TABLE_ENTRIES(TABLE_ENTRIES), .ADDR_BITS(ADDR_BITS)) u_dpath (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .in_opcode(s_tuser),
        .in_size(s_tdata[31:0]), .in_addr(s_tdata[63:32]), .sts(sts),
        .res_addr(res_addr), .res_status(res_status)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mv_reg <= 1'b0;
        end else if (cmd.out_load) begin
            mv_reg <= 1'b1;
        end else if (out_fire) begin
            mv_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            md_reg <= res_addr;
            mu_reg <= res_status;
        end
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = md_reg;
    assign m_tuser  = mu_reg;

    `ASSERT_CLK(a_no_overwrite, !(cmd.out_load && mv_reg && !out_fire),
        "result overwritten while held")
    `ASSERT_CLK(a_ready_idle, !(s_tready && cmd.scan_step), "ready while scanning")
    `ASSERT_NEXT(a_load_valid, cmd.out_load, m_tvalid, "loaded result not shown")
endmodule

/* test/ffba_checker.sv */
// Checker for the first-fit block allocator: predicts results and compares them.
`timescale 1ns / 1ps
module ffba_checker #(
    parameter int TABLE_ENTRIES = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [63:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    input  logic [1:0]  m_tuser,
    output int          fail_count,
    output int          pending,
    output int          result_count
);
    import ffba_pkg::*;

    typedef struct packed {
        logic [31:0] addr;
        status_t     status;
    } alloc_result_t;

    logic [31:0] blk_base [TABLE_ENTRIES];
    logic [31:0] blk_len  [TABLE_ENTRIES];
    estat_t      blk_stat [TABLE_ENTRIES];
    alloc_result_t expected_results [$];

    function automatic status_t model_alloc(input logic [31:0] size, output logic [31:0] addr);
        int fit;
        int spare;
        fit = -1;
        spare = -1;
        addr = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (blk_stat[i] == E_FREE && fit < 0 && blk_len[i] >= size) fit = i;
            else if (blk_stat[i] == E_UNUSED && spare < 0) spare = i;
            if (fit >= 0 && spare >= 0) break;
        end
        if (fit < 0) return ST_NO_FIT;
        if (spare < 0) return ST_FULL;
        blk_stat[spare] = E_USED;
        blk_base[spare] = blk_base[fit];
        blk_len[spare] = size;
        blk_base[fit] = blk_base[fit] + size;
        blk_len[fit] = blk_len[fit] - size;
        if (blk_len[fit] == 0) blk_stat[fit] = E_UNUSED;
        addr = blk_base[spare];
        return ST_OK;
    endfunction

    function automatic status_t model_free(input logic [31:0] addr);
        int cur;
        int lower;
        int higher;
        logic [31:0] cur_end;
        cur = -1;
        lower = -1;
        higher = -1;
        for (int i = 0; i < TABLE_ENTRIES; i++)
            if (blk_stat[i] == E_USED && blk_base[i] == addr) begin
                cur = i;
                break;
            end
        if (cur < 0) return ST_NOT_FOUND;
        blk_stat[cur] = E_FREE;
        cur_end = blk_base[cur] + blk_len[cur];
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (i == cur || blk_stat[i] != E_FREE) continue;
            if (lower < 0 && blk_base[i] + blk_len[i] == blk_base[cur]) lower = i;
            else if (higher < 0 && blk_base[i] == cur_end) higher = i;
            if (lower >= 0 && higher >= 0) break;
        end
        if (lower >= 0) begin
            blk_len[lower] = blk_len[lower] + blk_len[cur];
            blk_stat[cur] = E_UNUSED;
            cur = lower;
        end
        if (higher >= 0) begin
            blk_len[cur] = blk_len[cur] + blk_len[higher];
            blk_stat[higher] = E_UNUSED;
        end
        return ST_OK;
    endfunction

    function automatic status_t model_add(input logic [31:0] start, input logic [31:0] size);
        int spare;
        spare = -1;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (blk_stat[i] == E_FREE && blk_base[i] + blk_len[i] == start) begin
                blk_len[i] = blk_len[i] + size;
                return ST_OK;
            end
            if (blk_stat[i] == E_UNUSED) spare = i;
        end
        if (spare < 0) return ST_FULL;
        blk_base[spare] = start;
        blk_len[spare] = size;
        blk_stat[spare] = E_FREE;
        return ST_OK;
    endfunction

    assign pending = expected_results.size();

    always @(posedge aclk) begin
        alloc_result_t exp_r;
        alloc_result_t got;
        logic [31:0] a;
        if (!aresetn) begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                blk_stat[i] = E_UNUSED;
                blk_base[i] = '0;
                blk_len[i] = '0;
            end
            expected_results.delete();
            fail_count <= 0;
            result_count <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.addr = m_tdata;
                got.status = status_t'(m_tuser);
                result_count <= result_count + 1;
                if (expected_results.size() == 0) begin
                    $error("result with nothing expected: addr %h status %0d",
                        got.addr, got.status);
                    fail_count <= fail_count + 1;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (got.addr !== exp_r.addr || got.status !== exp_r.status) begin
                        fail_count <= fail_count + 1;
                        if (got.addr !== exp_r.addr)
                            $error("result_address: expected %h, actual %h",
                                exp_r.addr, got.addr);
                        if (got.status !== exp_r.status)
                            $error("status_code: expected %0d, actual %0d",
                                exp_r.status, got.status);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                a = '0;
                exp_r.addr = '0;
                case (opcode_t'(s_tuser))
                    OP_ALLOC: begin
                        exp_r.status = model_alloc(s_tdata[31:0], a);
                        exp_r.addr = a;
                    end
                    OP_FREE: exp_r.status = model_free(s_tdata[63:32]);
                    OP_ADD: begin
                        exp_r.status = model_add(s_tdata[63:32], s_tdata[31:0]);
                        if (exp_r.status == ST_OK) exp_r.addr = s_tdata[63:32];
                    end
                    default: exp_r.status = ST_OK;
                endcase
                if (exp_r.status != ST_OK) exp_r.addr = '0;
                expected_results.push_back(exp_r);
            end
        end
    end
endmodule

/* test/testbench.sv */
// Stimulus and verdict for the first-fit block allocator test.
`timescale 1ns / 1ps
module testbench;
    import ffba_pkg::*;

    localparam int Entries = 256;
    localparam int StallLimit = 20000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic [1:0]  s_tuser = OP_NONE;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;
    int          fail_count;
    int          pending;
    int          result_count;
    int          idle_cycles = 0;
    logic        calm = 1'b0;
    logic [31:0] granted [$];
    int          op_counts [4] = '{0, 0, 0, 0};

    always #10 aclk = ~aclk;

    first_fit_block_allocator_top dut (.*);

    ffba_checker #(.TABLE_ENTRIES(Entries)) checker_i (.*);

    // Receiver stalls at random, except in the calm stretch.
    always @(negedge aclk) begin
        m_tready <= calm || ($urandom_range(99) >= 6);
    end

    // Remember granted addresses so that frees often hit a used block.
    always @(posedge aclk)
        if (m_tvalid && m_tready && m_tuser == ST_OK && m_tdata != 0 &&
                granted.size() < 400)
            granted.push_back(m_tdata);

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > StallLimit) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send(input opcode_t op, input logic [31:0] size, input logic [31:0] addr);
        if (!calm && $urandom_range(99) < 6) begin
            s_tvalid <= 1'b0;
            do @(negedge aclk); while (!calm && $urandom_range(99) < 6);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {addr, size};
        op_counts[op]++;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic rand_item();
        int sel;
        int k;
        logic [31:0] a;
        sel = $urandom_range(99);
        if (sel < 40) begin
            send(OP_ALLOC, ($urandom_range(3) == 0) ? $urandom : $urandom_range(512),
                $urandom);
        end else if (sel < 70) begin
            if (granted.size() > 0 && $urandom_range(4) != 0) begin
                k = $urandom_range(granted.size() - 1);
                a = granted[k];
                granted.delete(k);
            end else a = $urandom;
            send(OP_FREE, $urandom, a);
        end else if (sel < 95) begin
            send(OP_ADD, $urandom_range(4096),
                $urandom_range(3) * 32'h1000_0000 + $urandom_range(8191));
        end else if (sel < 98) send(OP_ADD, $urandom, $urandom);
        else send(OP_NONE, $urandom, $urandom);
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        // Directed part.
        send(OP_ALLOC, 32'd16, 32'd0);          // nothing fits in an empty table
        send(OP_FREE, 32'd0, 32'h1234);         // nothing to free
        send(OP_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send(OP_ADD, 32'h1000, 32'h1000);
        send(OP_ADD, 32'h1000, 32'h2000);       // grows the free block that ends here
        send(OP_ALLOC, 32'd0, 32'd0);           // zero bytes
        send(OP_ALLOC, 32'h100, 32'd0);
        send(OP_ALLOC, 32'h100, 32'd0);
        send(OP_ALLOC, 32'h100, 32'd0);
        send(OP_FREE, 32'd0, 32'h1100);         // frees a used block; no free block adjoins it
        send(OP_FREE, 32'd0, 32'h1000);         // frees the zero-byte block at this address
        send(OP_ALLOC, 32'h1E00, 32'd0);        // no free block is large enough
        send(OP_ALLOC, 32'hFFFF_FFFF, 32'd0);
        send(OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send(OP_ADD, 32'd0, 32'hFFFF_FFFE);     // zero-length region that adjoins the wrapped one
        send(OP_ALLOC, 32'hFFFF_FFFF, 32'd0);
        send(OP_FREE, 32'd0, 32'hFFFF_FFFF);
        send(OP_FREE, 32'd0, 32'h1000);
        // Fill the table so table-full cases appear.
        for (int i = 0; i < Entries + 4; i++) send(OP_ADD, 32'h10, 32'h4000_0000 + 32'h20 * i);
        for (int i = 0; i < 4; i++) send(OP_ALLOC, 32'h8, 32'd0);
        for (int i = 0; i < 720; i++) begin
            calm = (i >= 400 && i < 550);
            rand_item();
        end
        calm = 1'b1;
        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (2 * Entries + 20) @(posedge aclk);
        $display("Covered %0d allocate, %0d free, %0d add and %0d ignored operations,",
            op_counts[OP_ALLOC], op_counts[OP_FREE], op_counts[OP_ADD], op_counts[OP_NONE]);
        $display("with %0d results checked.", result_count);
        if (fail_count == 0 && pending == 0) $display("testbench: PASS");
        else $display("testbench: FAIL");
        $finish;
    end
endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/ffba_pkg.sv
rtl/core/ffba_ctrl.sv
rtl/core/ffba_dpath.sv
rtl/core/first_fit_block_allocator_top.sv
test/ffba_checker.sv
test/testbench.sv
